/* hw/rtl/tqv_pkg.sv */
// Shared widths, register indexes, state codes and helper functions of the tile quad vertex generator.
`default_nettype none

package tqv_pkg;

  // Field widths
  localparam int ID_W    = 16;   // tile id
  localparam int SIDE_W  = 11;   // layer width / height registers
  localparam int POS_W   = 10;   // column / row position
  localparam int PIX_W   = 9;    // tile size and atlas width
  localparam int XY_W    = 19;   // world coordinates
  localparam int UV_W    = 25;   // texture coordinates
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Limits
  localparam int MAX_LAYER_SIDE = 1024;
  localparam int MAX_PIX        = 256;

  // Serial units
  localparam int MUL_A_W     = ID_W;              // multiplicand width
  localparam int PROD_W      = MUL_A_W + PIX_W;   // product width
  localparam int DIV_CNT_W   = $clog2(ID_W + 1);
  localparam int MUL_CNT_W   = $clog2(PIX_W + 1);
  localparam int VTX_CNT_W   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ID     = 3'd4;

  // Vertex index of the last corner of a quad
  localparam logic [VTX_CNT_W-1:0] LAST_VTX = 3'd5;

  // Top level sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_EMIT = 4'b1000
  } tqv_state_t;

  // Divider result bundle
  typedef struct packed {
    logic             done;
    logic [ID_W-1:0]  quot;
    logic [PIX_W-1:0] rem;
  } tqv_div_res_t;

  // Multiplier result bundle
  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } tqv_mul_res_t;

  // Layer side clamped to 1..MAX_LAYER_SIDE
  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) r = SIDE_W'(1);
    else if (v > SIDE_W'(MAX_LAYER_SIDE)) r = SIDE_W'(MAX_LAYER_SIDE);
    else r = v;
    return r;
  endfunction

  // Pixel / atlas count clamped to 1..MAX_PIX
  function automatic logic [PIX_W-1:0] eff_pix(input logic [PIX_W-1:0] v);
    logic [PIX_W-1:0] r;
    if (v == '0) r = PIX_W'(1);
    else if (v > PIX_W'(MAX_PIX)) r = PIX_W'(MAX_PIX);
    else r = v;
    return r;
  endfunction

  // Corner select for vertex k: bit 1 = right edge, bit 0 = bottom edge
  function automatic logic [1:0] corner_sel(input logic [VTX_CNT_W-1:0] k);
    logic [1:0] r;
    case (k)
      3'd1:    r = 2'b10;
      3'd2:    r = 2'b11;
      3'd4:    r = 2'b11;
      3'd5:    r = 2'b01;
      default: r = 2'b00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tqv_tile_if.sv */
// Tile id input channel.
`default_nettype none

interface tqv_tile_if;
  import tqv_pkg::*;
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] tile_id;

  modport source (output valid, output tile_id, input ready);
  modport sink   (input valid, input tile_id, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tqv_vtx_if.sv */
// Vertex output channel.
`default_nettype none

interface tqv_vtx_if;
  import tqv_pkg::*;
  logic            valid;
  logic            ready;
  logic [XY_W-1:0] vertex_x;
  logic [XY_W-1:0] vertex_y;
  logic [UV_W-1:0] tex_u;
  logic [UV_W-1:0] tex_v;
  logic            bad_tile;
  logic            last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output tex_u,
                  output tex_v, output bad_tile, output last_vertex, input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input tex_u,
                  input tex_v, input bad_tile, input last_vertex, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tqv_cfg_if.sv */
// Configuration write channel.
`default_nettype none

interface tqv_cfg_if;
  import tqv_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tqv_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module tqv_div
  import tqv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [ID_W-1:0]  dividend,
  input  wire logic [PIX_W-1:0] divisor,
  output tqv_div_res_t          res
);

  logic [ID_W-1:0]      quot;
  logic [PIX_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [PIX_W:0]   trial;
  logic [PIX_W:0]   diff;
  logic             ge;
  logic [PIX_W-1:0] rem_next;

  // One restoring step: bring down the next dividend bit
  always_comb begin
    trial    = {rem, quot[ID_W-1]};
    ge       = trial >= {1'b0, divisor};
    diff     = trial - {1'b0, divisor};
    rem_next = ge ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= DIV_CNT_W'(ID_W);
    end else if (busy) begin
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath; quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[ID_W-2:0], ge};
      rem  <= rem_next;
    end
  end

  assign res.done = done;
  assign res.quot = quot;
  assign res.rem  = rem;

endmodule

`default_nettype wire

/* hw/rtl/tqv_mul.sv */
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
`default_nettype none

module tqv_mul
  import tqv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [PIX_W-1:0]   b,
  output tqv_mul_res_t            res
);

  logic [MUL_A_W-1:0]   a_q;
  logic [MUL_A_W-1:0]   hi;
  logic [PIX_W-1:0]     lo;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [MUL_A_W:0]     sum;

  // Partial sum of the upper half and the selected multiplicand
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, a_q} : '0);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= MUL_CNT_W'(PIX_W);
    end else if (busy) begin
      cnt <= cnt - MUL_CNT_W'(1);
      if (cnt == MUL_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Product register shifts right; multiplier bits leave at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      hi  <= '0;
      lo  <= b;
    end else if (busy) begin
      {hi, lo} <= {sum, lo[PIX_W-1:1]};
    end
  end

  assign res.done = done;
  assign res.prod = {hi, lo};

endmodule

`default_nettype wire

/* hw/rtl/tile_quad_vertex_generator_unit.sv */
// Top level: position tracking, serial atlas divide and scaling, vertex emission.
//
//   channel     | dir | handshake     | payload
//   ------------+-----+---------------+--------------------------------------------
//   tile_in     | in  | valid/ready   | tile_id
//   vertex_out  | out | valid/ready   | vertex_x, vertex_y, tex_u, tex_v, bad_tile,
//               |     |               | last_vertex
//   cfg         | in  | valid/ready   | index, data (always ready)
//
// An empty tile (id zero) is accepted and only advances the position. A non-empty tile
// is accepted, then runs through the serial divider (16 quotient bits plus a hand-off)
// and the serial multipliers (9 tile-size bits plus a hand-off), then emits 6 vertices.
// One tile is in flight at a time; tile_in is ready only when the sequencer is idle.
// Output stalls hold the current vertex. Synchronous reset returns the registers to
// their defaults and the position to the origin.
`default_nettype none

module tile_quad_vertex_generator_unit
  import tqv_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  tqv_tile_if.sink    tile_in,
  tqv_vtx_if.source   vertex_out,
  tqv_cfg_if.sink     cfg
);

  // Configuration registers
  logic [SIDE_W-1:0] layer_width;
  logic [SIDE_W-1:0] layer_height;
  logic [PIX_W-1:0]  tile_size;
  logic [PIX_W-1:0]  atlas_width;
  logic [ID_W-1:0]   first_id;

  // Position and per-tile work registers
  logic [POS_W-1:0]     col_pos;
  logic [POS_W-1:0]     row_pos;
  logic [POS_W-1:0]     col_w;
  logic [POS_W-1:0]     row_w;
  logic                 bad;
  logic [VTX_CNT_W-1:0] vtx;
  tqv_state_t           state;
  tqv_state_t           state_next;

  logic [SIDE_W-1:0] w_eff;
  logic [SIDE_W-1:0] h_eff;
  logic [PIX_W-1:0]  ts_eff;
  logic [PIX_W-1:0]  aw_eff;

  logic              accept;
  logic              id_zero;
  logic              id_bad;
  logic [ID_W-1:0]   offset;
  logic              div_start;
  logic              mul_start;
  logic              out_fire;
  logic [SIDE_W-1:0] col_inc;
  logic [SIDE_W-1:0] row_inc;

  tqv_div_res_t div_res;
  tqv_mul_res_t mul_u;
  tqv_mul_res_t mul_v;
  tqv_mul_res_t mul_x;
  tqv_mul_res_t mul_y;

  logic [1:0]      corner;
  logic [XY_W-1:0] x0;
  logic [XY_W-1:0] y0;
  logic [UV_W-1:0] u0;
  logic [UV_W-1:0] v0;

  // Clamped register values
  assign w_eff  = eff_side(layer_width);
  assign h_eff  = eff_side(layer_height);
  assign ts_eff = eff_pix(tile_size);
  assign aw_eff = eff_pix(atlas_width);

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_width  <= SIDE_W'(1);
      layer_height <= SIDE_W'(1);
      tile_size    <= PIX_W'(16);
      atlas_width  <= PIX_W'(1);
      first_id     <= ID_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LAYER_WIDTH:  layer_width  <= cfg.data[SIDE_W-1:0];
        REG_LAYER_HEIGHT: layer_height <= cfg.data[SIDE_W-1:0];
        REG_TILE_SIZE:    tile_size    <= cfg.data[PIX_W-1:0];
        REG_ATLAS_WIDTH:  atlas_width  <= cfg.data[PIX_W-1:0];
        REG_FIRST_ID:     first_id     <= cfg.data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // Input acceptance
  assign tile_in.ready = (state == ST_IDLE);
  assign accept        = tile_in.valid && tile_in.ready;
  assign id_zero       = (tile_in.tile_id == '0);
  assign id_bad        = (tile_in.tile_id < first_id);
  assign offset        = id_bad ? '0 : (tile_in.tile_id - first_id);
  assign div_start     = accept && !id_zero;
  assign mul_start     = (state == ST_DIV) && div_res.done;
  assign out_fire      = vertex_out.valid && vertex_out.ready;

  // Row-major position advance with wrap
  assign col_inc = {1'b0, col_pos} + SIDE_W'(1);
  assign row_inc = {1'b0, row_pos} + SIDE_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      if (col_inc >= w_eff) begin
        col_pos <= '0;
        row_pos <= (row_inc >= h_eff) ? '0 : row_inc[POS_W-1:0];
      end else begin
        col_pos <= col_inc[POS_W-1:0];
      end
    end
  end

  // Snapshot of the tile being worked on
  always_ff @(posedge clk) begin
    if (accept) begin
      col_w <= col_pos;
      row_w <= row_pos;
      bad   <= id_bad;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (div_start) state_next = ST_DIV;
      ST_DIV:  if (div_res.done) state_next = ST_MUL;
      ST_MUL:  if (mul_u.done) state_next = ST_EMIT;
      ST_EMIT: if (out_fire && vtx == LAST_VTX) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      vtx   <= '0;
    end else begin
      state <= state_next;
      if (mul_start) vtx <= '0;
      else if (out_fire) vtx <= vtx + VTX_CNT_W'(1);
    end
  end

  // Atlas column and row of the tile
  tqv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (offset),
    .divisor  (aw_eff),
    .res      (div_res)
  );

  // Scale atlas and layer positions by the tile size
  tqv_mul u_mul_u (
    .clk (clk), .rst (rst), .start (mul_start),
    .a   (MUL_A_W'(div_res.rem)), .b (ts_eff), .res (mul_u)
  );

  tqv_mul u_mul_v (
    .clk (clk), .rst (rst), .start (mul_start),
    .a   (div_res.quot), .b (ts_eff), .res (mul_v)
  );

  tqv_mul u_mul_x (
    .clk (clk), .rst (rst), .start (mul_start),
    .a   (MUL_A_W'(col_w)), .b (ts_eff), .res (mul_x)
  );

  tqv_mul u_mul_y (
    .clk (clk), .rst (rst), .start (mul_start),
    .a   (MUL_A_W'(row_w)), .b (ts_eff), .res (mul_y)
  );

  // Corner selection for the current vertex
  assign corner = corner_sel(vtx);
  assign x0     = mul_x.prod[XY_W-1:0];
  assign y0     = mul_y.prod[XY_W-1:0];
  assign u0     = mul_u.prod[UV_W-1:0];
  assign v0     = mul_v.prod[UV_W-1:0];

  assign vertex_out.valid       = (state == ST_EMIT);
  assign vertex_out.vertex_x    = corner[1] ? x0 + XY_W'(ts_eff) : x0;
  assign vertex_out.vertex_y    = corner[0] ? y0 + XY_W'(ts_eff) : y0;
  assign vertex_out.tex_u       = bad ? '0 : (corner[1] ? u0 + UV_W'(ts_eff) : u0);
  assign vertex_out.tex_v       = bad ? '0 : (corner[0] ? v0 + UV_W'(ts_eff) : v0);
  assign vertex_out.bad_tile    = bad;
  assign vertex_out.last_vertex = (vtx == LAST_VTX);

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    tile_in.ready |-> !vertex_out.valid)
    else $error("input ready while a vertex is pending");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    vertex_out.valid && vertex_out.ready && vertex_out.last_vertex |=> !vertex_out.valid)
    else $error("vertex output continued after the last vertex");

  a_bad_tex: assert property (@(posedge clk) disable iff (rst)
    vertex_out.valid && vertex_out.bad_tile |-> vertex_out.tex_u == '0 && vertex_out.tex_v == '0)
    else $error("flagged tile with nonzero texture coordinates");

  a_empty_silent: assert property (@(posedge clk) disable iff (rst)
    tile_in.valid && tile_in.ready && tile_in.tile_id == '0 |=> !vertex_out.valid && tile_in.ready)
    else $error("empty tile started work");

endmodule

`default_nettype wire

/* dv/tqv_vertex_checker.sv */
`timescale 1ns / 100ps
// Checker for the tile quad vertex generator: predicts the vertex stream and compares it.
module tqv_vertex_checker
  import tqv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tqv_tile_if  tile_mon,
  tqv_vtx_if   vtx_mon,
  tqv_cfg_if   cfg_mon,
  output int   errors,
  output int   pending_vertices
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    logic [UV_W-1:0] u;
    logic [UV_W-1:0] v;
    logic            bad;
    logic            last;
  } vertex_t;

  // Shadow copy of the registers and the cell position
  logic [SIDE_W-1:0] layer_w;
  logic [SIDE_W-1:0] layer_h;
  logic [PIX_W-1:0]  tile_px;
  logic [PIX_W-1:0]  atlas_w;
  logic [ID_W-1:0]   first_id;
  int unsigned       col_pos;
  int unsigned       row_pos;

  vertex_t expected_vertices[$];
  int      fail_total = 0;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void push_corner(longint unsigned x, longint unsigned y,
                                      longint unsigned u, longint unsigned v,
                                      logic bad, logic last);
    vertex_t item;
    item = '{x: XY_W'(x), y: XY_W'(y), u: UV_W'(u), v: UV_W'(v),
             bad: bad, last: last};
    expected_vertices = {expected_vertices, item};
  endfunction

  // Expand one tile into its two triangles, then step the position
  task automatic expand_tile(input logic [ID_W-1:0] id);
    longint unsigned ts, aw, ofs, du, x0, y0, u0, v0;
    logic bad;
    ts = clamp_to(tile_px, 1, MAX_PIX);
    aw = clamp_to(atlas_w, 1, MAX_PIX);
    if (id != '0) begin
      x0  = col_pos * ts;
      y0  = row_pos * ts;
      u0  = 0;
      v0  = 0;
      du  = 0;
      bad = 1'b0;
      if (id < first_id) begin
        // texture corners all at zero, world corners as usual
        bad = 1'b1;
      end else begin
        ofs = id - first_id;
        u0  = (ofs % aw) * ts;
        v0  = (ofs / aw) * ts;
        du  = ts;
      end
      push_corner(x0,      y0,      u0,      v0,      bad, 1'b0);
      push_corner(x0 + ts, y0,      u0 + du, v0,      bad, 1'b0);
      push_corner(x0 + ts, y0 + ts, u0 + du, v0 + du, bad, 1'b0);
      push_corner(x0,      y0,      u0,      v0,      bad, 1'b0);
      push_corner(x0 + ts, y0 + ts, u0 + du, v0 + du, bad, 1'b0);
      push_corner(x0,      y0 + ts, u0,      v0 + du, bad, 1'b1);
    end
    // a position left outside a shrunk layer wraps on the next step
    col_pos++;
    if (col_pos >= clamp_to(layer_w, 1, MAX_LAYER_SIDE)) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= clamp_to(layer_h, 1, MAX_LAYER_SIDE)) row_pos = 0;
    end
  endtask

  always @(posedge clk) begin
    vertex_t got;
    vertex_t want;
    if (rst) begin
      layer_w    = SIDE_W'(1);
      layer_h    = SIDE_W'(1);
      tile_px    = PIX_W'(16);
      atlas_w    = PIX_W'(1);
      first_id   = ID_W'(1);
      col_pos    = 0;
      row_pos    = 0;
      fail_total = 0;
      expected_vertices.delete();
    end else begin
      // register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_LAYER_WIDTH:  layer_w  = cfg_mon.data[SIDE_W-1:0];
          REG_LAYER_HEIGHT: layer_h  = cfg_mon.data[SIDE_W-1:0];
          REG_TILE_SIZE:    tile_px  = cfg_mon.data[PIX_W-1:0];
          REG_ATLAS_WIDTH:  atlas_w  = cfg_mon.data[PIX_W-1:0];
          REG_FIRST_ID:     first_id = cfg_mon.data[ID_W-1:0];
          default: ;
        endcase
      end
      // accepted tile item
      if (tile_mon.valid && tile_mon.ready) expand_tile(tile_mon.tile_id);
      // accepted vertex item
      if (vtx_mon.valid && vtx_mon.ready) begin
        got = '{vtx_mon.vertex_x, vtx_mon.vertex_y, vtx_mon.tex_u, vtx_mon.tex_v,
                vtx_mon.bad_tile, vtx_mon.last_vertex};
        if (expected_vertices.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_MAX)
            $display("%0t: unexpected vertex x=%0d y=%0d u=%0d v=%0d bad=%0b last=%0b",
                     $time, got.x, got.y, got.u, got.v, got.bad, got.last);
        end else begin
          want = expected_vertices.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.u !== want.u ||
              got.v !== want.v || got.bad !== want.bad || got.last !== want.last) begin
            fail_total++;
            if (fail_total <= REPORT_MAX)
              $display({"%0t: vertex mismatch: expected x=%0d y=%0d u=%0d v=%0d bad=%0b ",
                        "last=%0b, got x=%0d y=%0d u=%0d v=%0d bad=%0b last=%0b"},
                       $time, want.x, want.y, want.u, want.v, want.bad, want.last,
                       got.x, got.y, got.u, got.v, got.bad, got.last);
          end
        end
      end
    end
    errors           <= fail_total;
    pending_vertices <= expected_vertices.size();
  end

endmodule

/* dv/tb_tile_quad_vertex_generator_unit.sv */
`timescale 1ns / 100ps
// Testbench top for the tile quad vertex generator: stimulus, flow control and verdict.
module tb_tile_quad_vertex_generator_unit;
  import tqv_pkg::*;

  localparam int IDLE_GAP       = 40;    // quiet cycles before a register write
  localparam int HOLD_CYCLES    = 300;   // long output hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving
  localparam int SEG_ITEMS      = 43;    // random tiles per register setting
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tqv_tile_if tile_ch();
  tqv_vtx_if  vtx_ch();
  tqv_cfg_if  cfg_ch();

  int check_errors;
  int pending_vertices;
  int send_idle_pct = 8;
  int recv_idle_pct = 45;
  int hold_req_cnt  = 0;
  int hold_done_cnt = 0;
  int idle_cycles   = 0;
  logic [ID_W-1:0] cur_first = ID_W'(1);

  tile_quad_vertex_generator_unit dut (
    .clk        (clk),
    .rst        (rst),
    .tile_in    (tile_ch),
    .vertex_out (vtx_ch),
    .cfg        (cfg_ch)
  );

  tqv_vertex_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .tile_mon         (tile_ch),
    .vtx_mon          (vtx_ch),
    .cfg_mon          (cfg_ch),
    .errors           (check_errors),
    .pending_vertices (pending_vertices)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on cycles where no item moves on any channel
  always @(posedge clk) begin
    if ((tile_ch.valid && tile_ch.ready) || (vtx_ch.valid && vtx_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Vertex receiver: random stalls, plus a long hold-off on request
  initial begin
    vtx_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done_cnt != hold_req_cnt) begin
        vtx_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done_cnt++;
      end else begin
        vtx_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one tile item, with random gaps ahead of it; valid stays high afterwards
  task automatic send_tile(input logic [ID_W-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      tile_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tile_ch.valid   <= 1'b1;
    tile_ch.tile_id <= id;
    do @(posedge clk); while (!tile_ch.ready);
  endtask

  // Stop offering and wait for every predicted vertex
  task automatic wait_drain();
    tile_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_vertices != 0);
  endtask

  // Drain, then let an empty tile still in the pipe finish
  task automatic wait_idle();
    wait_drain();
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                               input logic [CFG_DATA_W-1:0] ts,
                               input logic [CFG_DATA_W-1:0] aw,
                               input logic [CFG_DATA_W-1:0] fid);
    write_reg(REG_LAYER_WIDTH, w);
    write_reg(REG_LAYER_HEIGHT, h);
    write_reg(REG_TILE_SIZE, ts);
    write_reg(REG_ATLAS_WIDTH, aw);
    write_reg(REG_FIRST_ID, fid);
    cfg_ch.valid <= 1'b0;
    cur_first = fid[ID_W-1:0];
  endtask

  // Mostly small layers so the position wraps often; out-of-range values now and then
  task automatic random_setting();
    logic [CFG_DATA_W-1:0] w, h, ts, aw, fid;
    case ($urandom_range(9))
      0:       w = 16'd1024;
      1:       w = 16'd0;
      2:       w = 16'($urandom);
      default: w = 16'($urandom_range(8, 1));
    endcase
    case ($urandom_range(9))
      0:       h = 16'd1024;
      1:       h = 16'd0;
      2:       h = 16'($urandom);
      default: h = 16'($urandom_range(6, 1));
    endcase
    case ($urandom_range(9))
      0:       ts = 16'd256;
      1:       ts = 16'd0;
      2:       ts = 16'($urandom);
      default: ts = 16'($urandom_range(256, 1));
    endcase
    case ($urandom_range(9))
      0:       aw = 16'd256;
      1:       aw = 16'd0;
      2:       aw = 16'($urandom);
      3:       aw = 16'd1;
      default: aw = 16'($urandom_range(16, 1));
    endcase
    case ($urandom_range(9))
      0:       fid = 16'd0;
      1:       fid = 16'hFFFF;
      2:       fid = 16'($urandom);
      3:       fid = 16'($urandom_range(1000, 100));
      default: fid = 16'($urandom_range(8));
    endcase
    apply_setting(w, h, ts, aw, fid);
  endtask

  // Mix of empty cells, ids below the first id, ids near it and fully random ids
  function automatic logic [ID_W-1:0] pick_tile_id();
    int unsigned sel;
    int unsigned id;
    sel = $urandom_range(99);
    if (sel < 20) id = 0;
    else if (sel < 32 && cur_first > 1) id = $urandom_range(cur_first - 1, 1);
    else if (sel < 75) id = cur_first + $urandom_range(600);
    else id = $urandom_range(65535);
    return ID_W'(id);
  endfunction

  initial begin
    int phase;
    int seg;
    int cnt;
    tile_ch.valid   <= 1'b0;
    tile_ch.tile_id <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Reset defaults: one-cell layer, 16 px tiles, one-wide atlas, first id 1
    send_tile(16'd0);
    send_tile(16'd1);
    send_tile(16'hFFFF);
    wait_idle();

    // Largest tiles and atlas, first id zero; a write to an unused index is ignored
    write_reg(REG_UNUSED, 16'hFFFF);
    apply_setting(16'd4, 16'd3, 16'd256, 16'd256, 16'd0);
    send_tile(16'hFFFF);
    send_tile(16'd256);
    send_tile(16'd255);
    send_tile(16'd1);
    send_tile(16'd0);
    send_tile(16'd7);
    wait_idle();

    // Largest layer, tile size above range, atlas width zero, first id at its top
    apply_setting(16'd1024, 16'd1024, 16'd511, 16'd0, 16'hFFFF);
    send_tile(16'hFFFF);
    send_tile(16'hFFFE);
    send_tile(16'd1);
    wait_idle();

    // Width zero, height above range, tile size zero, atlas width above range
    apply_setting(16'd0, 16'd2047, 16'd0, 16'd511, 16'd100);
    send_tile(16'd99);
    send_tile(16'd100);
    send_tile(16'd356);
    send_tile(16'd0);
    wait_idle();

    // Walk along a wide row, then shrink the layer under the current position
    apply_setting(16'd1024, 16'd1024, 16'd16, 16'd4, 16'd1);
    send_tile(16'd3);
    send_tile(16'd0);
    send_tile(16'd0);
    send_tile(16'd0);
    send_tile(16'd9);
    wait_idle();
    apply_setting(16'd2, 16'd2, 16'd16, 16'd4, 16'd1);
    send_tile(16'd6);
    send_tile(16'd7);

    // Random part: three flow-control phases, two register settings each
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (seg = 0; seg < 2; seg++) begin
        wait_idle();
        random_setting();
        for (cnt = 0; cnt < SEG_ITEMS; cnt++) begin
          // output held off while tiles keep coming
          if (phase == 0 && seg == 0 && cnt == 10) hold_req_cnt++;
          // sender pause until the output has caught up
          if (phase == 1 && seg == 1 && cnt == 20) wait_drain();
          send_tile(pick_tile_id());
        end
      end
    end

    wait_drain();
    repeat (IDLE_GAP) @(posedge clk);
    if (check_errors == 0 && pending_vertices == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
